// ===== hw/rtl/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// Potential phase rotator package
// Word types, CORDIC constants and the Q2.30 to Q1.15 rounding helper.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int ROTATION_STAGES_DEFAULT = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int XY_W = 34;
  localparam int Z_W = 32;
  localparam int Q15_W = 40;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;

  localparam logic [Z_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [23:0] potential;
    logic signed [15:0] psi_re;
    logic signed [15:0] psi_im;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] factor_re;
    logic signed [15:0] factor_im;
    logic signed [15:0] rotated_re;
    logic signed [15:0] rotated_im;
  } result_t;

  typedef struct packed {
    logic                   valid;
    logic                   flip;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic signed [15:0]     psi_re;
    logic signed [15:0]     psi_im;
  } cell_t;

  function automatic logic signed [15:0] to_q15(input logic signed [Q15_W-1:0] v);
    logic signed [Q15_W-1:0] t;
    logic signed [Q15_W-1:0] r;
    t = v + Q15_W'(16384);
    r = t >>> 15;
    if (r > Q15_W'(32767)) begin
      return 16'sh7FFF;
    end else if (r < -Q15_W'(32768)) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

endpackage

// ===== hw/rtl/ppr_cell.sv =====
// ----------------------------------------------------------------------------
// Potential phase rotator CORDIC cell
// One rotation micro-step; hands the rotated vector to the next cell.
// ----------------------------------------------------------------------------
module ppr_cell
  import ppr_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t d,
  output cell_t q
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  step;
  cell_t                  q_next;

  assign dx = d.y >>> STAGE;
  assign dy = d.x >>> STAGE;
  assign step = $signed(ATAN_TURNS[STAGE]);

  always_comb begin
    q_next = d;
    if (!d.z[Z_W-1]) begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - step;
    end else begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== hw/rtl/ppr_post.sv =====
// ----------------------------------------------------------------------------
// Potential phase rotator output stages
// Quadrant fix, Q1.15 factor, complex multiply, rounding and saturation.
// ----------------------------------------------------------------------------
module ppr_post
  import ppr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cell_t   d,
  output logic    result_valid,
  output result_t result
);

  logic signed [XY_W:0] xf;
  logic signed [XY_W:0] yf;

  logic               v1;
  logic signed [15:0] fr;
  logic signed [15:0] fi;
  logic signed [15:0] pr;
  logic signed [15:0] pi;

  logic               v2;
  logic signed [15:0] fr2;
  logic signed [15:0] fi2;
  logic signed [31:0] p_fr_pr;
  logic signed [31:0] p_fi_pi;
  logic signed [31:0] p_fr_pi;
  logic signed [31:0] p_fi_pr;

  logic signed [Q15_W-1:0] sum_re;
  logic signed [Q15_W-1:0] sum_im;

  // The factor is conj of the rotated vector; a flipped angle negates both parts.
  always_comb begin
    xf = (XY_W+1)'(d.x);
    yf = -(XY_W+1)'(d.y);
    if (d.flip) begin
      xf = -(XY_W+1)'(d.x);
      yf = (XY_W+1)'(d.y);
    end
  end

  assign sum_re = Q15_W'(p_fr_pr) - Q15_W'(p_fi_pi);
  assign sum_im = Q15_W'(p_fr_pi) + Q15_W'(p_fi_pr);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1 <= d.valid;
      fr <= to_q15(Q15_W'(xf));
      fi <= to_q15(Q15_W'(yf));
      pr <= d.psi_re;
      pi <= d.psi_im;

      v2 <= v1;
      fr2 <= fr;
      fi2 <= fi;
      p_fr_pr <= fr * pr;
      p_fi_pi <= fi * pi;
      p_fr_pi <= fr * pi;
      p_fi_pr <= fi * pr;

      result_valid <= v2;
      result.factor_re <= fr2;
      result.factor_im <= fi2;
      result.rotated_re <= to_q15(sum_re);
      result.rotated_im <= to_q15(sum_im);
    end
  end

endmodule

// ===== hw/rtl/potential_phase_rotator.sv =====
// ----------------------------------------------------------------------------
// Potential phase rotator
// Applies the split-operator potential half-step factor to one sample word.
// ----------------------------------------------------------------------------
// The sample channel (sample_valid, sample_stall, sample_word) carries one
// potential value and one complex Q1.15 sample per word. The result channel
// (result_valid, result_stall, result_word) returns the factor cos - i*sin of
// the angle potential*phase_scale (turns, modulo one) and the rotated sample.
// phase_scale is written through cfg_write and cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this. One
// word is accepted per cycle while sample_stall is low. The angle multiply of
// a word is registered at the accepting edge; the word then passes the chain
// of CORDIC cells and the factor rounding, complex multiply and output registers.
// While the receiver stalls a valid result, the whole pipeline holds and
// sample_stall is raised; it drops as soon as the result word is taken.
// Reset clears phase_scale and all valid flags; no words are in flight after.
// ----------------------------------------------------------------------------
module potential_phase_rotator
  import ppr_pkg::*;
#(
  parameter int ROTATION_STAGES = ROTATION_STAGES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample_word,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result_word
);

  localparam int CELLS = (ROTATION_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : ROTATION_STAGES;

  logic [31:0]        phase_scale;
  logic               en;
  logic [23:0]        prod;
  logic               ang_valid;
  logic [23:0]        ang;
  logic signed [15:0] ang_psi_re;
  logic signed [15:0] ang_psi_im;
  logic               flip;
  cell_t              chain [CELLS+1];

  assign en = !(result_valid && result_stall);
  assign sample_stall = !en;
  assign prod = sample_word.potential * phase_scale[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_scale <= 32'd0;
    end else if (cfg_write) begin
      phase_scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_valid <= 1'b0;
    end else if (en) begin
      ang_valid <= sample_valid;
      ang <= prod;
      ang_psi_re <= sample_word.psi_re;
      ang_psi_im <= sample_word.psi_im;
    end
  end

  // Angles in the left half-plane are turned by half a turn and negated later.
  assign flip = ang[23] ^ ang[22];

  always_comb begin
    chain[0].valid = ang_valid;
    chain[0].flip = flip;
    chain[0].x = CORDIC_GAIN;
    chain[0].y = '0;
    chain[0].z = {ang[23] ^ flip, ang[22:0], 8'b0};
    chain[0].psi_re = ang_psi_re;
    chain[0].psi_im = ang_psi_im;
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    ppr_cell #(
      .STAGE(i)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .en(en),
      .d(chain[i]),
      .q(chain[i+1])
    );
  end

  ppr_post u_post (
    .clk(clk),
    .rst(rst),
    .en(en),
    .d(chain[CELLS]),
    .result_valid(result_valid),
    .result(result_word)
  );

endmodule

// ===== hw/rtl/ppr_checker.sv =====
// ----------------------------------------------------------------------------
// Potential phase rotator checker
// Port-level assertions on flow control, reset and the unit-magnitude factor.
// ----------------------------------------------------------------------------
module ppr_checker
  import ppr_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result_word
);

  logic signed [32:0] mag_sq;

  assign mag_sq = 33'(result_word.factor_re) * 33'(result_word.factor_re)
                + 33'(result_word.factor_im) * 33'(result_word.factor_im);

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_word))
    else $error("stalled result word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_unit_factor: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> mag_sq > 33'sd1069547520 && mag_sq < 33'sd1077936128)
    else $error("phase factor is not of unit magnitude");

endmodule

bind potential_phase_rotator ppr_checker u_ppr_checker (
  .clk(clk),
  .rst(rst),
  .sample_stall(sample_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result_word(result_word)
);

// ===== tb/potential_phase_rotator_tb.sv =====
// ----------------------------------------------------------------------------
// Potential phase rotator testbench
// Streams sample words through the rotator under several phase_scale settings
// and checks every result word against a bit-exact CORDIC predictor. A short
// table of directed words covers the reset scale, the flip boundaries, whole
// turns and saturating products; random words follow, with both sides of the
// handshake idling at random.
// ----------------------------------------------------------------------------
module potential_phase_rotator_tb;
  import ppr_pkg::*;

  localparam int ROT_STAGES = ROTATION_STAGES_DEFAULT;
  localparam int RANDOM_PHASES = 11;
  localparam int WORDS_PER_PHASE = 150;
  localparam int NO_IDLE_PHASE = 6;
  localparam int DRAIN_CYCLES = ROT_STAGES + 12;

  typedef struct packed {
    logic [31:0]        scale;
    sample_t            word;
    logic               rot_known;
    logic signed [15:0] rot_re;
    logic signed [15:0] rot_im;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 21;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{32'h00000000, '{24'sh000000, 16'sh0000, 16'sh0000}, 1'b1, 16'sh0000, 16'sh0000},
    '{32'h00000000, '{24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00000000, '{24'sh800000, 16'sh8000, 16'sh8000}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00000000, '{24'sh123456, 16'sh8000, 16'sh7FFF}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'hFFFFFFFF, '{24'sh000001, 16'sh0000, 16'sh0000}, 1'b1, 16'sh0000, 16'sh0000},
    '{32'hFFFFFFFF, '{24'sh7FFFFF, 16'sh7FFF, 16'sh8000}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'hFFFFFFFF, '{24'sh800000, 16'sh8000, 16'sh7FFF}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'hFFFFFFFF, '{24'shFFFFFF, 16'sh4000, 16'shC000}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h01000000, '{24'sh2AAAAA, 16'sh8000, 16'sh8000}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h01000000, '{24'sh555555, 16'sh0000, 16'sh0000}, 1'b1, 16'sh0000, 16'sh0000},
    '{32'h00400000, '{24'sh000001, 16'sh7FFF, 16'sh0000}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00400000, '{24'shFFFFFF, 16'sh0000, 16'sh7FFF}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00400000, '{24'sh000002, 16'sh8000, 16'sh8000}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00400000, '{24'sh000004, 16'sh1234, 16'sh8765}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00200000, '{24'sh000001, 16'sh8000, 16'sh8000}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00200000, '{24'sh000003, 16'sh7FFF, 16'sh7FFF}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00200000, '{24'sh000005, 16'sh8000, 16'sh7FFF}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00800000, '{24'sh000001, 16'sh7FFF, 16'sh7FFF}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00800000, '{24'sh800000, 16'sh8000, 16'sh8000}, 1'b0, 16'sh0000, 16'sh0000},
    '{32'h00800000, '{24'sh3FFFFF, 16'sh0000, 16'sh0000}, 1'b1, 16'sh0000, 16'sh0000},
    '{32'h003FFFFF, '{24'sh000001, 16'sh7FFF, 16'sh8000}, 1'b0, 16'sh0000, 16'sh0000}
  };

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [31:0] cfg_data;
  logic        sample_valid;
  logic        sample_stall;
  sample_t     sample_word;
  logic        result_valid;
  logic        result_stall;
  result_t     result_word;

  result_t     pending_results[$];
  logic [31:0] active_scale;
  bit          no_idle;
  int          words_checked;
  int          mismatches;
  int          scales_used;

  potential_phase_rotator #(
    .ROTATION_STAGES(ROT_STAGES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_word(sample_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word(result_word)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint sat_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r;
  endfunction

  function automatic result_t rotate_by_potential(input sample_t w, input logic [31:0] scale);
    longint  prod;
    longint  x;
    longint  y;
    longint  z;
    longint  dx;
    longint  dy;
    longint  fr;
    longint  fi;
    longint  pr;
    longint  pi;
    logic [31:0] ang;
    bit      flip;
    result_t r;
    prod = longint'(w.potential) * $signed({32'b0, scale});
    ang = {prod[23:0], 8'b0};
    flip = (ang >= 32'h40000000) && (ang < 32'hC0000000);
    if (flip) ang = ang - 32'h80000000;
    z = longint'($signed(ang));
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < ROT_STAGES && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - $signed({32'b0, ATAN_TURNS[i]});
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + $signed({32'b0, ATAN_TURNS[i]});
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    pr = longint'(w.psi_re);
    pi = longint'(w.psi_im);
    fr = sat_q15(x);
    fi = sat_q15(-y);
    r.factor_re = fr[15:0];
    r.factor_im = fi[15:0];
    r.rotated_re = 16'(sat_q15(fr * pr - fi * pi));
    r.rotated_im = 16'(sat_q15(fr * pi + fi * pr));
    return r;
  endfunction

  // Hands one word to the block and records its expected result on acceptance.
  task automatic send_word(input sample_t w, input bit has_override,
                           input logic signed [15:0] rot_re,
                           input logic signed [15:0] rot_im);
    result_t exp_r;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 26) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_word <= w;
    do @(posedge clk); while (sample_stall);
    exp_r = rotate_by_potential(w, active_scale);
    if (has_override) begin
      exp_r.rotated_re = rot_re;
      exp_r.rotated_im = rot_im;
    end
    pending_results.push_back(exp_r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_scale(input logic [31:0] value);
    drain_results();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    active_scale = value;
    scales_used++;
  endtask

  function automatic logic [23:0] pick_potential();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(7)) - 24'd3;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_psi();
    case ($urandom_range(11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(negedge clk) begin
    result_stall <= !rst && !no_idle && ($urandom_range(99) < 26);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result word %h", result_word);
        end
      end else begin
        result_t exp_r;
        exp_r = pending_results.pop_front();
        words_checked++;
        if (result_word.factor_re !== exp_r.factor_re
            || result_word.factor_im !== exp_r.factor_im
            || result_word.rotated_re !== exp_r.rotated_re
            || result_word.rotated_im !== exp_r.rotated_im) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at word %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     words_checked, exp_r.factor_re, exp_r.factor_im, exp_r.rotated_re,
                     exp_r.rotated_im, result_word.factor_re, result_word.factor_im,
                     result_word.rotated_re, result_word.rotated_im);
          end
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [31:0] scale;
    sample_t     w;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    sample_valid = 1'b0;
    sample_word = '0;
    active_scale = '0;
    no_idle = 1'b0;
    words_checked = 0;
    mismatches = 0;
    scales_used = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      if (DIRECTED[n].scale != active_scale) set_scale(DIRECTED[n].scale);
      send_word(DIRECTED[n].word, DIRECTED[n].rot_known, DIRECTED[n].rot_re,
                DIRECTED[n].rot_im);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: scale = 32'hFFFFFFFF;
        1: scale = 32'h00000000;
        2: scale = 32'h00000001;
        3: scale = 32'h80000000;
        4: scale = 32'($urandom_range(1023));
        default: scale = $urandom;
      endcase
      set_scale(scale);
      no_idle = (p == NO_IDLE_PHASE);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        w.potential = pick_potential();
        w.psi_re = pick_psi();
        w.psi_im = pick_psi();
        send_word(w, 1'b0, 16'sh0000, 16'sh0000);
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d result words over %0d phase_scale settings, %0d mismatches.",
             words_checked, scales_used, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
